[hdl/stunp_pkg.sv]
// ----------------------------------------------------------------------------
// stunp_pkg
// Shared types, constants and the CRC byte step for the STUN response parser.
// ----------------------------------------------------------------------------
package stunp_pkg;

    localparam int HDR_LEN = 20;

    localparam logic [15:0] MSG_BIND_RESP = 16'h0101;
    localparam logic [31:0] MAGIC_COOKIE  = 32'h2112_A442;
    localparam logic [31:0] FP_XOR        = 32'h5354_554E;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

    localparam logic [15:0] ATTR_MAPPED   = 16'h0001;
    localparam logic [15:0] ATTR_XMAPPED  = 16'h0020;
    localparam logic [15:0] ATTR_CHANGED  = 16'h0005;
    localparam logic [15:0] ATTR_SOURCE   = 16'h0004;
    localparam logic [15:0] ATTR_RORIGIN  = 16'h802B;
    localparam logic [15:0] ATTR_OTHER    = 16'h802C;
    localparam logic [15:0] ATTR_FPRINT   = 16'h8028;

    localparam logic [2:0] SLOT_MAPPED  = 3'd0;
    localparam logic [2:0] SLOT_CHANGED = 3'd1;
    localparam logic [2:0] SLOT_SOURCE  = 3'd2;
    localparam logic [2:0] SLOT_RORIGIN = 3'd3;
    localparam logic [2:0] SLOT_OTHER   = 3'd4;

    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic CFG_TXID_HIGH = 1'b0;
    localparam logic CFG_TXID_LOW  = 1'b1;

    // parse flag bits
    localparam int FL_RECV = 0;
    localparam int FL_STOP = 1;
    localparam int FL_BAD  = 2;
    localparam int FL_FPOK = 3;

    typedef struct packed {
        logic        kind;
        logic [2:0]  addr_slot;
        logic        addr_valid;
        logic [31:0] ip_addr;
        logic [15:0] port_num;
        logic        received;
        logic        fingerprint_ok;
        logic        last;
    } t_result;

    // up to two results per input beat; a single one always sits in res0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result res0;
        t_result res1;
    } t_push;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

[hdl/stun_response_parser.sv]
// ----------------------------------------------------------------------------
// stun_response_parser
// STUN binding response parser with address reports and fingerprint check.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one message byte per beat in s_axis_tdata, s_axis_tlast on
//   the final byte of the datagram.
//   Master stream: result items. tuser is the kind (address report or
//   end-of-packet status), tlast marks the last result caused by one byte.
//   Config channel: index 0 writes txid_high, index 1 txid_low; write only
//   while the block is idle. Always ready.
//   Latency: a result enters the queue as its byte is taken and is offered the cycle after if the queue was empty.
//   Throughput: one byte per cycle; the parser and CRC update one byte per
//   cycle. A byte may cause two results, which drain through a four-entry
//   queue at one per cycle; s_axis_tready drops while fewer than two entries
//   are free, so a stalled receiver stalls the input once three results wait.
//   Bytes that cause no result keep flowing until then.
//   Reset: packet state cleared, CRC to all ones, transaction ID to zero,
//   queue emptied. End of packet returns the parser to that state but keeps
//   the transaction ID.
// ----------------------------------------------------------------------------
module stun_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_packet
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [2:0] addr_slot, [3] addr_valid, [35:4] ip_addr,
                                        // [51:36] port_num, [52] received,
                                        // [53] fingerprint_ok, [55:54] zero
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import stunp_pkg::*;

    logic [31:0] r_txid_high;
    logic [63:0] r_txid_low;
    logic        room;
    logic        beat;
    t_push       push;
    t_result     res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room;
    assign beat          = s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txid_high <= '0;
            r_txid_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TXID_HIGH: r_txid_high <= i_cfg_data[31:0];
                CFG_TXID_LOW:  r_txid_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stunp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_byte      (s_axis_tdata),
        .i_eop       (s_axis_tlast),
        .i_txid_high (r_txid_high),
        .i_txid_low  (r_txid_low),
        .o_push      (push)
    );

    stunp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.fingerprint_ok, res.received, res.port_num,
                           res.ip_addr, res.addr_valid, res.addr_slot};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

[hdl/stunp_front.sv]
// ----------------------------------------------------------------------------
// stunp_front
// Byte parser: header checks, attribute walk, CRC, result generation.
// ----------------------------------------------------------------------------
module stunp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_beat,
    input  logic [7:0]            i_byte,
    input  logic                  i_eop,
    input  logic [31:0]           i_txid_high,
    input  logic [63:0]           i_txid_low,
    output stunp_pkg::t_push      o_push
);
    import stunp_pkg::*;

    logic [4:0]  r_hpos, n_hpos;
    logic [15:0] r_blen, n_blen;
    logic [16:0] r_bpos, n_bpos;
    logic [15:0] r_atype, n_atype;
    logic [15:0] r_alen, n_alen;
    logic [16:0] r_apos, n_apos;
    logic [63:0] r_vs, n_vs;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_csnap, n_csnap;
    logic [3:0]  r_flags, n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos  <= '0;
            r_blen  <= '0;
            r_bpos  <= '0;
            r_atype <= '0;
            r_alen  <= '0;
            r_apos  <= '0;
            r_vs    <= '0;
            r_crc   <= '1;
            r_csnap <= '0;
            r_flags <= '0;
        end else begin
            r_hpos  <= n_hpos;
            r_blen  <= n_blen;
            r_bpos  <= n_bpos;
            r_atype <= n_atype;
            r_alen  <= n_alen;
            r_apos  <= n_apos;
            r_vs    <= n_vs;
            r_crc   <= n_crc;
            r_csnap <= n_csnap;
            r_flags <= n_flags;
        end
    end

    always_comb begin
        logic [4:0]  tx_k;
        logic [7:0]  want;
        logic [16:0] bp1;
        logic [16:0] ap1;
        logic [16:0] padded;
        logic [2:0]  off;
        logic        fin;
        logic        is_addr;
        logic        xr;
        logic [2:0]  slot;
        t_result     rep;
        t_result     sts;

        n_hpos  = r_hpos;
        n_blen  = r_blen;
        n_bpos  = r_bpos;
        n_atype = r_atype;
        n_alen  = r_alen;
        n_apos  = r_apos;
        n_vs    = r_vs;
        n_crc   = r_crc;
        n_csnap = r_csnap;
        n_flags = r_flags;
        tx_k    = '0;
        want    = '0;
        bp1     = '0;
        ap1     = '0;
        padded  = '0;
        off     = '0;
        fin     = 1'b0;
        is_addr = 1'b0;
        xr      = 1'b0;
        slot    = SLOT_MAPPED;
        rep     = '0;
        sts     = '0;
        o_push  = '0;

        if (i_beat) begin
            n_crc = crc_byte(r_crc, i_byte);
            if (r_hpos < 5'(HDR_LEN)) begin
                if (r_hpos < 5'd2) begin
                    n_vs = {r_vs[55:0], i_byte};
                    if (r_hpos == 5'd1 && {r_vs[7:0], i_byte} != MSG_BIND_RESP)
                        n_flags[FL_BAD] = 1'b1;
                end else if (r_hpos < 5'd4) begin
                    n_blen = {r_blen[7:0], i_byte};
                end else if (r_hpos >= 5'd8) begin
                    if (r_hpos < 5'd12) begin
                        tx_k = 5'd11 - r_hpos;
                        want = i_txid_high[{tx_k[1:0], 3'b000} +: 8];
                    end else begin
                        tx_k = 5'd19 - r_hpos;
                        want = i_txid_low[{tx_k[2:0], 3'b000} +: 8];
                    end
                    if (want != i_byte)
                        n_flags[FL_BAD] = 1'b1;
                end
                n_hpos = r_hpos + 5'd1;
                if (n_hpos == 5'(HDR_LEN) && !n_flags[FL_BAD]) begin
                    n_flags[FL_RECV] = 1'b1;
                    n_vs   = '0;
                    n_bpos = '0;
                    n_apos = '0;
                end
            end else if (r_flags[FL_RECV] && !r_flags[FL_STOP]) begin
                if (r_apos == '0) begin
                    if ({1'b0, r_bpos} + 18'd4 > {2'b00, r_blen})
                        n_flags[FL_STOP] = 1'b1;
                    else
                        n_csnap = r_crc;
                end
                if (!n_flags[FL_STOP]) begin
                    if (r_apos < 17'd2) begin
                        n_atype = {r_atype[7:0], i_byte};
                    end else if (r_apos < 17'd4) begin
                        n_alen = {r_alen[7:0], i_byte};
                    end else if (r_apos - 17'd4 < 17'd8) begin
                        off = r_apos[2:0] - 3'd4;
                        n_vs[{3'd7 - off, 3'b000} +: 8] = i_byte;
                    end
                    bp1 = r_bpos + 17'd1;
                    ap1 = r_apos + 17'd1;
                    if (r_apos == 17'd3) begin
                        n_vs = '0;
                        if ({1'b0, bp1} + {2'b00, n_alen} > {2'b00, r_blen})
                            n_flags[FL_STOP] = 1'b1;
                    end
                    if (r_apos >= 17'd3 && !n_flags[FL_STOP]) begin
                        padded = ({1'b0, n_alen} + 17'd3) & ~17'd3;
                        if (ap1 == 17'd4 + {1'b0, n_alen})
                            fin = 1'b1;
                        if ({1'b0, ap1} >= 18'd4 + {1'b0, padded})
                            ap1 = '0;
                    end
                    n_bpos = bp1;
                    n_apos = ap1;
                end
            end

            if (fin) begin
                is_addr = 1'b1;
                case (n_atype)
                    ATTR_MAPPED:  slot = SLOT_MAPPED;
                    ATTR_XMAPPED: begin
                        slot = SLOT_MAPPED;
                        xr   = 1'b1;
                    end
                    ATTR_CHANGED: slot = SLOT_CHANGED;
                    ATTR_SOURCE:  slot = SLOT_SOURCE;
                    ATTR_RORIGIN: slot = SLOT_RORIGIN;
                    ATTR_OTHER:   slot = SLOT_OTHER;
                    ATTR_FPRINT: begin
                        is_addr = 1'b0;
                        if (n_alen >= 16'd4)
                            n_flags[FL_FPOK] = ((~n_csnap) ^ FP_XOR) == n_vs[63:32];
                    end
                    default: is_addr = 1'b0;
                endcase
            end

            rep.kind      = KIND_ADDR;
            rep.addr_slot = slot;
            if (n_alen >= 16'd8 && n_vs[55:48] == 8'd1) begin
                rep.addr_valid = 1'b1;
                rep.ip_addr    = n_vs[31:0] ^ (xr ? MAGIC_COOKIE : 32'd0);
                rep.port_num   = n_vs[47:32] ^ (xr ? MAGIC_COOKIE[31:16] : 16'd0);
            end
            rep.received       = n_flags[FL_RECV];
            rep.fingerprint_ok = n_flags[FL_FPOK];
            rep.last           = !i_eop;

            sts.kind           = KIND_STATUS;
            sts.received       = n_flags[FL_RECV];
            sts.fingerprint_ok = n_flags[FL_FPOK];
            sts.last           = 1'b1;

            if (is_addr) begin
                o_push.v0   = 1'b1;
                o_push.res0 = rep;
                o_push.v1   = i_eop;
                o_push.res1 = sts;
            end else begin
                o_push.v0   = i_eop;
                o_push.res0 = sts;
            end

            if (i_eop) begin
                n_hpos  = '0;
                n_blen  = '0;
                n_bpos  = '0;
                n_atype = '0;
                n_alen  = '0;
                n_apos  = '0;
                n_vs    = '0;
                n_crc   = '1;
                n_csnap = '0;
                n_flags = '0;
            end
        end
    end

endmodule

[hdl/stunp_queue.sv]
// ----------------------------------------------------------------------------
// stunp_queue
// Four-entry result queue, two writes and one read per cycle.
// ----------------------------------------------------------------------------
module stunp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stunp_pkg::t_push      i_push,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_ready,
    output stunp_pkg::t_result    o_res
);
    import stunp_pkg::*;

    t_result     r_mem [4];
    logic [1:0]  r_wp, n_wp;
    logic [1:0]  r_rp, n_rp;
    logic [2:0]  r_cnt, n_cnt;
    logic        pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // front may add two items per beat
    assign o_room  = (r_cnt <= 3'd2);

    always_comb begin
        n_wp  = r_wp + {1'b0, i_push.v0} + {1'b0, i_push.v1};
        n_rp  = r_rp + {1'b0, pop};
        n_cnt = r_cnt + {2'b00, i_push.v0} + {2'b00, i_push.v1} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0)
            r_mem[r_wp] <= i_push.res0;
        if (i_push.v1)
            r_mem[r_wp + 2'd1] <= i_push.res1;
    end

endmodule

[tb/sv/tb_stun_response_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stun_response_parser
// Streams generated STUN responses (good, corrupted, truncated, noisy) into
// the parser and checks every address report and end-of-packet status
// against a cycle-independent model kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb_stun_response_parser;
    import stunp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    stun_response_parser i_dut (.*);

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // parser model state
    logic [31:0] txid_hi;
    logic [63:0] txid_lo;
    int          hdr_pos, body_len, body_pos, attr_type, attr_len, attr_pos;
    logic [63:0] vshift;
    logic [31:0] crc_run, crc_snap;
    logic        f_recv, f_stop, f_bad, f_fpok;

    t_result     report_q[$];
    int          errors;
    bit          gaps_on, stall_on, hold_req;
    int          stall_left, hold_cnt;

    function automatic logic [31:0] crc_upd(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        return c;
    endfunction

    task automatic packet_clear();
        hdr_pos = 0; body_len = 0; body_pos = 0;
        attr_type = 0; attr_len = 0; attr_pos = 0;
        vshift = '0; crc_run = '1; crc_snap = '0;
        f_recv = 0; f_stop = 0; f_bad = 0; f_fpok = 0;
    endtask

    task automatic push_report(input logic kind, input logic [2:0] slot, input logic valid,
                               input logic [31:0] ip, input logic [15:0] port);
        t_result r;
        r.kind = kind; r.addr_slot = slot; r.addr_valid = valid;
        r.ip_addr = ip; r.port_num = port;
        r.received = f_recv; r.fingerprint_ok = f_fpok; r.last = 1'b0;
        report_q.push_back(r);
    endtask

    task automatic attr_done(inout int n);
        logic [2:0]  slot;
        logic        xr;
        logic [31:0] ip;
        logic [15:0] port;
        xr = 0;
        case (attr_type[15:0])
            ATTR_MAPPED:  slot = SLOT_MAPPED;
            ATTR_XMAPPED: begin slot = SLOT_MAPPED; xr = 1; end
            ATTR_CHANGED: slot = SLOT_CHANGED;
            ATTR_SOURCE:  slot = SLOT_SOURCE;
            ATTR_RORIGIN: slot = SLOT_RORIGIN;
            ATTR_OTHER:   slot = SLOT_OTHER;
            ATTR_FPRINT: begin
                if (attr_len >= 4) f_fpok = ((~crc_snap ^ FP_XOR) == vshift[63:32]);
                return;
            end
            default: return;
        endcase
        if (attr_len >= 8 && vshift[55:48] == 8'd1) begin
            port = vshift[47:32];
            ip   = vshift[31:0];
            if (xr) begin
                port ^= MAGIC_COOKIE[31:16];
                ip   ^= MAGIC_COOKIE;
            end
            push_report(KIND_ADDR, slot, 1'b1, ip, port);
        end else begin
            push_report(KIND_ADDR, slot, 1'b0, 32'd0, 16'd0);
        end
        n++;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eop);
        logic [31:0] crc_prev;
        logic [7:0]  want;
        int          ap, n, padded;
        n = 0;
        crc_prev = crc_run;
        crc_run = crc_upd(crc_run, b);
        if (hdr_pos < HDR_LEN) begin
            if (hdr_pos < 2) begin
                vshift = {vshift[55:0], b};
                if (hdr_pos == 1 && vshift[15:0] != MSG_BIND_RESP) f_bad = 1;
            end else if (hdr_pos < 4) begin
                body_len = ((body_len << 8) | b) & 16'hFFFF;
            end else if (hdr_pos >= 8) begin
                want = (hdr_pos < 12) ? txid_hi[8*(11-hdr_pos) +: 8]
                                      : txid_lo[8*(19-hdr_pos) +: 8];
                if (want != b) f_bad = 1;
            end
            hdr_pos++;
            if (hdr_pos == HDR_LEN && !f_bad) begin
                f_recv = 1; vshift = '0; body_pos = 0; attr_pos = 0;
            end
        end else if (f_recv && !f_stop) begin
            if (attr_pos == 0) begin
                if (body_pos + 4 > body_len) f_stop = 1;
                else crc_snap = crc_prev;
            end
            if (!f_stop) begin
                ap = attr_pos;
                if (ap < 2) attr_type = ((attr_type << 8) | b) & 16'hFFFF;
                else if (ap < 4) attr_len = ((attr_len << 8) | b) & 16'hFFFF;
                else if (ap - 4 < 8) vshift[56-8*(ap-4) +: 8] |= b;
                body_pos++;
                attr_pos++;
                if (ap == 3) begin
                    vshift = '0;
                    if (body_pos + attr_len > body_len) f_stop = 1;
                end
                if (ap >= 3 && !f_stop) begin
                    padded = (attr_len + 3) & ~3;
                    if (attr_pos == 4 + attr_len) attr_done(n);
                    if (attr_pos >= 4 + padded) attr_pos = 0;
                end
            end
        end
        if (eop) begin
            push_report(KIND_STATUS, 3'd0, 1'b0, 32'd0, 16'd0);
            n++;
            packet_clear();
        end
        if (n > 0) report_q[$].last = 1'b1;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (report_q.size() == 0) begin
                $display("%0t unexpected result tdata=%h tuser=%b tlast=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                r = report_q.pop_front();
                if (m_axis_tdata !== {2'b00, r.fingerprint_ok, r.received, r.port_num,
                                      r.ip_addr, r.addr_valid, r.addr_slot}
                    || m_axis_tuser !== r.kind || m_axis_tlast !== r.last) begin
                    $display("%0t mismatch exp kind=%b slot=%0d v=%b ip=%h port=%h rx=%b fp=%b last=%b",
                             $time, r.kind, r.addr_slot, r.addr_valid, r.ip_addr,
                             r.port_num, r.received, r.fingerprint_ok, r.last);
                    $display("%0t          act tdata=%h tuser=%b tlast=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eop;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b, eop);
    endtask

    task automatic send_bytes(input logic [7:0] bq[$], input bit end_with_eop);
        foreach (bq[i]) send_byte(bq[i], end_with_eop && i == bq.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TXID_HIGH) txid_hi = val[31:0];
        else txid_lo = val;
    endtask

    task automatic set_txid(input logic [31:0] hi, input logic [63:0] lo);
        wait_drained();
        write_reg(CFG_TXID_HIGH, {$urandom, hi});
        write_reg(CFG_TXID_LOW, lo);
        @(posedge i_clk);
    endtask

    // builds one response; mostly well formed, sometimes damaged
    task automatic build_response(output logic [7:0] pk[$], output bit trunc);
        logic [15:0] atype, alen, blen;
        logic [31:0] fp;
        int          nattr, sel, pad;
        logic [15:0] types[9];
        types = '{ATTR_MAPPED, ATTR_XMAPPED, ATTR_CHANGED, ATTR_SOURCE, ATTR_RORIGIN,
                  ATTR_OTHER, ATTR_FPRINT, 16'h8022, 16'h0000};
        pk = {};
        if ($urandom_range(0, 9) == 0) pk = {8'($urandom), 8'($urandom)};
        else pk = {MSG_BIND_RESP[15:8], MSG_BIND_RESP[7:0]};
        pk.push_back(8'h00); pk.push_back(8'h00);
        for (int i = 0; i < 4; i++) pk.push_back(MAGIC_COOKIE[8*(3-i) +: 8]);
        for (int i = 0; i < 4; i++) pk.push_back(txid_hi[8*(3-i) +: 8]);
        for (int i = 0; i < 8; i++) pk.push_back(txid_lo[8*(7-i) +: 8]);
        if ($urandom_range(0, 11) == 0) pk[$urandom_range(8, 19)] ^= 8'd1 << $urandom_range(0, 7);
        nattr = $urandom_range(0, 4);
        for (int a = 0; a < nattr; a++) begin
            sel = $urandom_range(0, 8);
            atype = (sel == 8) ? 16'($urandom) : types[sel];
            if (sel == 6) alen = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 3)) : 16'd4;
            else if ($urandom_range(0, 4) == 0) alen = 16'($urandom_range(0, 13));
            else alen = 16'd8;
            pk.push_back(atype[15:8]); pk.push_back(atype[7:0]);
            pk.push_back(alen[15:8]);  pk.push_back(alen[7:0]);
            fp = '1;
            foreach (pk[i]) if (i < pk.size() - 4) fp = crc_upd(fp, pk[i]);
            fp = ~fp ^ FP_XOR;
            if ($urandom_range(0, 4) == 0) fp ^= $urandom;
            pad = (alen + 3) & ~3;
            for (int i = 0; i < pad; i++) begin
                if (sel == 6 && i < 4) pk.push_back(fp[8*(3-i) +: 8]);
                else if (i == 1 && $urandom_range(0, 5) != 0) pk.push_back(8'd1);
                else pk.push_back(8'($urandom));
            end
        end
        blen = 16'(pk.size() - 20);
        case ($urandom_range(0, 9))
            0: blen = blen + 16'($urandom_range(1, 8));
            1: blen = (blen > 4) ? blen - 16'($urandom_range(1, 4)) : blen;
            2: blen = 16'($urandom);
            default: ;
        endcase
        pk[2] = blen[15:8]; pk[3] = blen[7:0];
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 6)) pk.push_back(8'($urandom));
        trunc = ($urandom_range(0, 9) == 0);
        if (trunc) pk = pk[0:$urandom_range(0, pk.size() - 1)];
    endtask

    task automatic run_responses(input int n_items);
        logic [7:0] pk[$];
        bit         trunc;
        int         sent;
        sent = 0;
        while (sent < n_items) begin
            build_response(pk, trunc);
            if ($urandom_range(0, 19) == 0) begin
                // noise without a packet end until its last byte, which closes it
                pk = {};
                repeat ($urandom_range(1, 30)) pk.push_back(8'($urandom));
            end
            send_bytes(pk, 1'b1);
            sent += pk.size();
        end
    endtask

    task automatic test_directed();
        logic [7:0] hq[$];
        set_txid(32'h0, 64'h0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // short packet ending inside the header
        hq = {8'h01, 8'h01, 8'h00, 8'h08, 8'h21, 8'h12, 8'hA4, 8'h42, 8'h00, 8'h00};
        send_bytes(hq, 1'b1);
        // header only, zero body, matching all-zero ID
        hq = {8'h01, 8'h01, 8'h00, 8'h00, 8'h21, 8'h12, 8'hA4, 8'h42};
        repeat (12) hq.push_back(8'h00);
        send_bytes(hq, 1'b1);
    endtask

    task automatic test_txid_sweep();
        set_txid(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        run_responses(300);
        set_txid(32'h0, 64'h0);
        run_responses(200);
        set_txid($urandom, {$urandom, $urandom});
        run_responses(300);
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        run_responses(120);
        wait_drained();
        run_responses(150);
    endtask

    task automatic test_tail_clean();
        set_txid($urandom, {$urandom, $urandom});
        gaps_on = 0;
        stall_on = 0;
        run_responses(300);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_TXID_HIGH; i_cfg_data = '0;
        errors = 0; gaps_on = 1; stall_on = 1; hold_req = 0;
        stall_left = 0; hold_cnt = 0;
        txid_hi = '0; txid_lo = '0;
        packet_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_txid_sweep();
        test_backpressure();
        test_tail_clean();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
